/* rtl/mtcf_pkg.sv */
// Shared types and constants for the track chunk framer.
// Used by the interfaces' users, the front end, the command queue and the back end.
// No dependencies.
package mtcf_pkg;

   // Item operations on the request channel.
   typedef enum logic [1:0] {
      OP_TRACK_BYTE  = 2'd0,
      OP_START_TRACK = 2'd1,
      OP_END_TRACK   = 2'd2
   } op_type;

   // Track byte classes.
   typedef enum logic [1:0] {
      DT_RAW  = 2'd0,
      DT_FULL = 2'd1,
      DT_EVEN = 2'd2,
      DT_ODD  = 2'd3
   } data_class_type;

   // Result kinds on the response channel.
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_CHUNK   = 2'd1,
      KIND_BLOCK   = 2'd2
   } result_kind_type;

   // Chunk codes.
   localparam logic [1:0] CODE_NONE = 2'd0;
   localparam logic [1:0] CODE_SYNC = 2'd1;
   localparam logic [1:0] CODE_DATA = 2'd2;

   // Track gap replayed at the start of a track.
   localparam logic [7:0]  GAP_BYTE   = 8'hAA;
   localparam logic [23:0] GAP_LENGTH = 24'd4;

   // Everything the back end needs to expand one item into its results.
   typedef struct packed {
      logic        has_chunk;
      logic        has_block;
      logic        has_pay;
      logic        gap;
      logic [2:0]  chunk_code;
      logic [23:0] chunk_bytes;
      logic [1:0]  count_width;
      logic [23:0] block_size;
      logic [23:0] block_offset;
      logic [7:0]  pay_byte;
   } frame_cmd_type;

   // One result item as it leaves the block.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [2:0]  chunk_code;
      logic [23:0] chunk_bytes;
      logic [1:0]  count_width;
      logic [23:0] block_size;
      logic [23:0] block_offset;
      logic        last;
   } result_type;

endpackage

/* rtl/mtcf_if.sv */
// Valid/ready channel interfaces of the track chunk framer.
// Request carries typed track items, response carries payload bytes and records.
// No dependencies.
interface mtcf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [1:0] data_type;
   logic [7:0] value;

   modport source (output valid, op, data_type, value, input ready);
   modport sink   (input valid, op, data_type, value, output ready);
endinterface

interface mtcf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  byte_value;
   logic [2:0]  chunk_code;
   logic [23:0] chunk_bytes;
   logic [1:0]  count_width;
   logic [23:0] block_size;
   logic [23:0] block_offset;
   logic        last;

   modport source (output valid, kind, byte_value, chunk_code, chunk_bytes, count_width,
                   block_size, block_offset, last, input ready);
   modport sink   (input valid, kind, byte_value, chunk_code, chunk_bytes, count_width,
                   block_size, block_offset, last, output ready);
endinterface

/* rtl/mtcf_queue.sv */
// Small FIFO of framing commands between the front end and the back end.
// Depends on mtcf_pkg for the command type.
module mtcf_queue #(
   parameter int Depth = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mtcf_pkg::frame_cmd_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mtcf_pkg::frame_cmd_type out_data
);
   import mtcf_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   frame_cmd_type         slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   // Occupancy flags and head of the queue.
   assign in_ready  = (count_ff != CountWidth'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; unread slots are never presented.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* rtl/mtcf_front.sv */
// Front end of the track chunk framer: accepts items, keeps the track counters
// and turns each item that has results into one framing command. Depends on mtcf_pkg and mtcf_req_if.
module mtcf_front (
   input  logic                    clock,
   input  logic                    reset,
   mtcf_req_if.sink                req_ch,
   output logic                    cmd_valid,
   output mtcf_pkg::frame_cmd_type cmd_data,
   input  logic                    cmd_ready
);
   import mtcf_pkg::*;

   logic [1:0]  code_ff, code_in;
   logic [23:0] chunk_ff, chunk_in;
   logic [23:0] decoded_ff, decoded_in;
   logic [23:0] area_ff, area_in;
   logic [23:0] begin_ff, begin_in;
   logic        phase_ff, phase_in;
   logic [3:0]  held_ff, held_in;

   logic        accept;
   logic        start;
   logic        do_close;
   logic        do_block;
   logic [1:0]  new_code;
   logic [1:0]  item_code;
   logic [1:0]  cw;
   logic [7:0]  x_shift;
   logic [3:0]  nib;
   logic        pay;
   logic [7:0]  pay_byte;
   logic [1:0]  dec_add;
   logic        phase_base;
   logic [2:0]  close_inc;
   logic [23:0] area_close;

   // Number of bytes needed to write a chunk length big-endian.
   function automatic logic [1:0] count_width_of(input logic [23:0] c);
      logic [1:0] w;
      if (c[23:16] != '0) begin
         w = 2'd3;
      end else if (c[15:8] != '0) begin
         w = 2'd2;
      end else if (c[7:0] != '0) begin
         w = 2'd1;
      end else begin
         w = 2'd0;
      end
      return w;
   endfunction

   assign req_ch.ready = cmd_ready;
   assign accept       = req_ch.valid && cmd_ready;

   // Classify the item: chunk change, block close, payload byte and counter steps.
   always_comb begin
      start     = 1'b0;
      do_close  = 1'b0;
      new_code  = CODE_NONE;
      item_code = (req_ch.data_type == DT_RAW) ? CODE_SYNC : CODE_DATA;
      cw        = count_width_of(chunk_ff);
      unique case (req_ch.op)
         OP_START_TRACK: start = 1'b1;
         OP_END_TRACK: begin
            do_close = 1'b1;
            new_code = CODE_NONE;
         end
         OP_TRACK_BYTE: begin
            do_close = (item_code != code_ff);
            new_code = item_code;
         end
         default: ;
      endcase
      do_block   = do_close && (new_code != CODE_DATA);
      phase_base = do_close ? 1'b0 : phase_ff;

      // Cell halves: the data bits sit in even positions after the even-cell shift.
      x_shift = (req_ch.data_type == DT_EVEN) ? {1'b0, req_ch.value[7:1]} : req_ch.value;
      nib     = {x_shift[6], x_shift[4], x_shift[2], x_shift[0]};

      pay      = 1'b0;
      pay_byte = req_ch.value;
      dec_add  = 2'd0;
      phase_in = phase_base;
      held_in  = held_ff;
      if (req_ch.op == OP_TRACK_BYTE) begin
         unique case (req_ch.data_type)
            DT_RAW: begin
               pay     = 1'b1;
               dec_add = 2'd1;
            end
            DT_FULL: begin
               pay     = 1'b1;
               dec_add = 2'd2;
            end
            default: begin
               dec_add = 2'd1;
               if (!phase_base) begin
                  held_in  = nib;
                  phase_in = 1'b1;
               end else begin
                  pay      = 1'b1;
                  pay_byte = {held_ff, nib};
                  phase_in = 1'b0;
               end
            end
         endcase
      end

      // Area grows by the chunk header, its count bytes and the end marker.
      close_inc  = do_close ? (3'd1 + {1'b0, cw} + {2'b00, do_block}) : 3'd0;
      area_close = area_ff + {21'd0, close_inc};

      code_in    = do_close ? new_code : code_ff;
      chunk_in   = (do_close ? 24'd0 : chunk_ff) + {23'd0, pay};
      decoded_in = (do_block ? 24'd0 : decoded_ff) + {22'd0, dec_add};
      area_in    = area_close + {23'd0, pay};
      begin_in   = do_block ? area_close : begin_ff;

      // Start of track replays the gap and resets the per-track counters.
      if (start) begin
         code_in    = CODE_SYNC;
         chunk_in   = GAP_LENGTH;
         decoded_in = GAP_LENGTH;
         area_in    = GAP_LENGTH;
         begin_in   = '0;
         phase_in   = 1'b0;
         held_in    = '0;
      end
   end

   // Command toward the back end; items without results send nothing.
   always_comb begin
      cmd_data              = '0;
      cmd_data.has_chunk    = do_close;
      cmd_data.has_block    = do_block;
      cmd_data.has_pay      = pay;
      cmd_data.gap          = start;
      cmd_data.chunk_code   = {1'b0, code_ff};
      cmd_data.chunk_bytes  = chunk_ff;
      cmd_data.count_width  = cw;
      cmd_data.block_size   = decoded_ff;
      cmd_data.block_offset = begin_ff;
      cmd_data.pay_byte     = pay_byte;
      cmd_valid             = accept && (start || do_close || pay);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff    <= CODE_SYNC;
         chunk_ff   <= '0;
         decoded_ff <= '0;
         area_ff    <= '0;
         begin_ff   <= '0;
         phase_ff   <= 1'b0;
         held_ff    <= '0;
      end else if (accept) begin
         code_ff    <= code_in;
         chunk_ff   <= chunk_in;
         decoded_ff <= decoded_in;
         area_ff    <= area_in;
         begin_ff   <= begin_in;
         phase_ff   <= phase_in;
         held_ff    <= held_in;
      end
   end

endmodule

/* rtl/mtcf_back.sv */
// Back end of the track chunk framer: expands each queued command into its result items,
// one per cycle unless rsp stalls, through an output register. Depends on mtcf_pkg, mtcf_rsp_if.
module mtcf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  mtcf_pkg::frame_cmd_type cmd_data,
   mtcf_rsp_if.source              rsp_ch
);
   import mtcf_pkg::*;

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   logic [1:0] last_idx;
   logic [1:0] block_idx;
   logic       is_last;
   logic       load;

   // Position of the current result within the command's list.
   always_comb begin
      if (cmd_data.gap) begin
         last_idx = 2'd3;
      end else begin
         last_idx = {1'b0, cmd_data.has_chunk} + {1'b0, cmd_data.has_block}
                  + {1'b0, cmd_data.has_pay} - 2'd1;
      end
      block_idx = cmd_data.has_chunk ? 2'd1 : 2'd0;
      is_last   = (step_ff == last_idx);
      load      = cmd_valid && (!valid_ff || rsp_ch.ready);
      cmd_ready = load && is_last;
   end

   // Records come first, then the payload byte or the gap bytes.
   always_comb begin
      result_in      = '0;
      result_in.last = is_last;
      priority if (cmd_data.has_chunk && (step_ff == 2'd0)) begin
         result_in.kind        = KIND_CHUNK;
         result_in.chunk_code  = cmd_data.chunk_code;
         result_in.chunk_bytes = cmd_data.chunk_bytes;
         result_in.count_width = cmd_data.count_width;
      end else if (cmd_data.has_block && (step_ff == block_idx)) begin
         result_in.kind         = KIND_BLOCK;
         result_in.block_size   = cmd_data.block_size;
         result_in.block_offset = cmd_data.block_offset;
      end else begin
         result_in.kind       = KIND_PAYLOAD;
         result_in.byte_value = cmd_data.gap ? GAP_BYTE : cmd_data.pay_byte;
      end
   end

   // Output register and step counter.
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
         step_in  = is_last ? 2'd0 : step_ff + 2'd1;
      end else begin
         valid_in = valid_ff && !rsp_ch.ready;
         step_in  = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = result_ff.kind;
   assign rsp_ch.byte_value   = result_ff.byte_value;
   assign rsp_ch.chunk_code   = result_ff.chunk_code;
   assign rsp_ch.chunk_bytes  = result_ff.chunk_bytes;
   assign rsp_ch.count_width  = result_ff.count_width;
   assign rsp_ch.block_size   = result_ff.block_size;
   assign rsp_ch.block_offset = result_ff.block_offset;
   assign rsp_ch.last         = result_ff.last;

endmodule

/* rtl/mfm_track_chunk_framer.sv */
// Track chunk framer top level: front end, command queue and back end.
// Depends on mtcf_pkg, mtcf_if, mtcf_queue, mtcf_front and mtcf_back.
//
// Usage:
// The req channel takes one typed track item per cycle while ready (op, data_type, value):
// track bytes, start of track or end of track. The rsp channel returns payload
// bytes, chunk records and block records in stream order, with last set on
// the final result of each item. Items that give no result (first cell half,
// unused op) return nothing.
// Path: an accepted item's command is written into the command queue; its results
// are then loaded from the queue head into the output register and presented.
// Throughput: one item per cycle while the response side takes one result per
// cycle; the back end emits one result per cycle, so an item with several
// results (up to four, for a start of track) holds the back end until all of
// them are sent. The command queue (QueueDepth entries) absorbs these bursts.
// Reset: synchronous; clears the queue and output register and returns the
// track counters to their initial values (sync chunk, all counts zero).
// Stall: when rsp is not ready the output holds, the queue fills, and req
// ready drops once the queue is full.
module mfm_track_chunk_framer #(
   parameter int QueueDepth = 4
) (
   input logic          clock,
   input logic          reset,
   mtcf_req_if.sink     req_ch,
   mtcf_rsp_if.source   rsp_ch
);
   import mtcf_pkg::*;

   logic          q_in_valid;
   logic          q_in_ready;
   frame_cmd_type q_in_data;
   logic          q_out_valid;
   logic          q_out_ready;
   frame_cmd_type q_out_data;

   mtcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (q_in_valid),
      .cmd_data  (q_in_data),
      .cmd_ready (q_in_ready)
   );

   mtcf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   mtcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_out_valid),
      .cmd_ready (q_out_ready),
      .cmd_data  (q_out_data),
      .rsp_ch    (rsp_ch)
   );

   // The front end only sends a command in a cycle the queue can take it.
   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      q_in_valid |-> q_in_ready)
      else $error("command pushed into a full queue");

   // After reset the block is empty and ready for an item.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_ch.valid && req_ch.ready))
      else $error("block not empty after reset");

   // The results of one item follow each other without gaps.
   a_item_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=> rsp_ch.valid)
      else $error("gap inside the results of one item");

   // A chunk record needs count bytes exactly when its length is nonzero.
   a_count_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == KIND_CHUNK))
         |-> ((rsp_ch.count_width == 2'd0) == (rsp_ch.chunk_bytes == 24'd0)))
      else $error("chunk record count width does not match its length");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the track chunk framer: typed track items in,
// payload bytes and chunk/block records out, checked against a local predictor.
// Depends on mtcf_pkg, mtcf_if and mfm_track_chunk_framer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mtcf_pkg::*;

   // One request item as queued for the driver.
   typedef struct packed {
      logic [1:0] op;
      logic [1:0] data_class;
      logic [7:0] value;
   } track_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtcf_req_if req_ch ();
   mtcf_rsp_if rsp_ch ();

   mfm_track_chunk_framer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Clock: 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Pending items, expected results and run statistics.
   track_item_type track_items[$];
   result_type     expected_q[$];
   track_item_type cur_item;
   int             fail_count     = 0;
   int             accepted_items = 0;
   int             results_seen   = 0;
   int             payload_seen   = 0;
   int             chunks_seen    = 0;
   int             blocks_seen    = 0;
   int             wide_chunks    = 0;
   logic           hold_off       = 1'b0;

   // Predictor state of the framer.
   logic [1:0]  frm_code        = CODE_SYNC;
   logic [23:0] frm_chunk_bytes = '0;
   logic [23:0] frm_decoded     = '0;
   logic [23:0] frm_area        = '0;
   logic [23:0] frm_block_begin = '0;
   logic        frm_phase       = 1'b0;
   logic [3:0]  frm_held        = '0;

   function automatic void add_item(logic [1:0] op, logic [1:0] dc, logic [7:0] v);
      track_item_type it;
      it.op = op;
      it.data_class = dc;
      it.value = v;
      track_items.push_back(it);
   endfunction

   // A payload byte advances both the area offset and the open chunk's length.
   function automatic void push_payload(logic [7:0] b);
      result_type r = '0;
      r.kind = KIND_PAYLOAD;
      r.byte_value = b;
      expected_q.push_back(r);
      frm_area = frm_area + 24'd1;
      frm_chunk_bytes = frm_chunk_bytes + 24'd1;
   endfunction

   // Close the open chunk; unless the next chunk is a data chunk, also close the block.
   function automatic void close_chunk(logic [1:0] new_code);
      result_type r = '0;
      logic [1:0] cnt_width = 2'd0;
      if (frm_chunk_bytes[23:16] != 8'd0) begin
         cnt_width = 2'd3;
      end else if (frm_chunk_bytes[15:8] != 8'd0) begin
         cnt_width = 2'd2;
      end else if (frm_chunk_bytes[7:0] != 8'd0) begin
         cnt_width = 2'd1;
      end
      r.kind = KIND_CHUNK;
      r.chunk_code = {1'b0, frm_code};
      r.chunk_bytes = frm_chunk_bytes;
      r.count_width = cnt_width;
      expected_q.push_back(r);
      frm_area = frm_area + 24'd1 + 24'(cnt_width);
      if (new_code != CODE_DATA) begin
         r = '0;
         r.kind = KIND_BLOCK;
         r.block_size = frm_decoded;
         r.block_offset = frm_block_begin;
         expected_q.push_back(r);
         frm_area = frm_area + 24'd1;
         frm_decoded = '0;
         frm_block_begin = frm_area;
      end
      frm_chunk_bytes = '0;
      frm_code = new_code;
      frm_phase = 1'b0;
   endfunction

   // Work out the results of one accepted item and queue them.
   function automatic void predict_framing(track_item_type it);
      int          first = expected_q.size();
      logic [1:0]  code;
      logic [7:0]  cells;
      logic [3:0]  nib;
      result_type  r;
      case (it.op)
         OP_START_TRACK: begin
            frm_code = CODE_SYNC;
            frm_chunk_bytes = '0;
            frm_area = '0;
            frm_decoded = GAP_LENGTH;
            frm_block_begin = '0;
            frm_phase = 1'b0;
            frm_held = '0;
            repeat (4) push_payload(GAP_BYTE);
         end
         OP_END_TRACK: begin
            close_chunk(CODE_NONE);
         end
         OP_TRACK_BYTE: begin
            code = (it.data_class == DT_RAW) ? CODE_SYNC : CODE_DATA;
            if (code != frm_code) close_chunk(code);
            if (it.data_class == DT_RAW || it.data_class == DT_FULL) begin
               push_payload(it.value);
               if (it.data_class == DT_FULL) frm_decoded = frm_decoded + 24'd1;
            end else begin
               // Data cells sit on the even bit positions after alignment.
               cells = (it.data_class == DT_EVEN) ? (it.value >> 1) : it.value;
               nib = {cells[6], cells[4], cells[2], cells[0]};
               if (!frm_phase) begin
                  frm_held = nib;
                  frm_phase = 1'b1;
               end else begin
                  push_payload({frm_held, nib});
                  frm_phase = 1'b0;
               end
            end
            frm_decoded = frm_decoded + 24'd1;
         end
         default: ;
      endcase
      if (expected_q.size() > first) begin
         r = expected_q.pop_back();
         r.last = 1'b1;
         expected_q.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Driver: bursts of items separated by random gaps.
   int burst_left = 1;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_framing(cur_item);
            accepted_items++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || track_items.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               cur_item = track_items.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.op <= cur_item.op;
               req_ch.data_type <= cur_item.data_class;
               req_ch.value <= cur_item.value;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Monitor: compare each accepted result and stall on a shifting pattern.
   int unsigned rsp_cycle = 0;
   always @(posedge clock) begin
      result_type want;
      logic       take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result: kind %0d, byte %0h", rsp_ch.kind, rsp_ch.byte_value);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("kind", 24'(want.kind), 24'(rsp_ch.kind));
               check_field("byte_value", 24'(want.byte_value), 24'(rsp_ch.byte_value));
               check_field("chunk_code", 24'(want.chunk_code), 24'(rsp_ch.chunk_code));
               check_field("chunk_bytes", want.chunk_bytes, rsp_ch.chunk_bytes);
               check_field("count_width", 24'(want.count_width), 24'(rsp_ch.count_width));
               check_field("block_size", want.block_size, rsp_ch.block_size);
               check_field("block_offset", want.block_offset, rsp_ch.block_offset);
               check_field("last", 24'(want.last), 24'(rsp_ch.last));
               results_seen++;
               case (want.kind)
                  KIND_PAYLOAD: payload_seen++;
                  KIND_CHUNK: begin
                     chunks_seen++;
                     if (want.count_width >= 2'd2) wide_chunks++;
                  end
                  default: blocks_seen++;
               endcase
            end
         end
         rsp_cycle++;
         case (rsp_cycle[8:7])
            2'd0: take = 1'b1;
            2'd1: take = (rsp_cycle % 5) != 0;
            2'd2: take = rsp_cycle[2:0] < 3'd3;
            default: take = $urandom_range(0, 3) != 0;
         endcase
         rsp_ch.ready <= take && !hold_off;
      end
   end

   // Long receiver hold-off so the command queue fills and req ready drops.
   initial begin
      wait (accepted_items >= 40);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (150) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Stimulus and end of run.
   initial begin
      int         n_runs;
      int         n;
      int         mode;
      int         target;
      logic [1:0] dc;
      req_ch.valid = 1'b0;
      req_ch.op = OP_TRACK_BYTE;
      req_ch.data_type = DT_RAW;
      req_ch.value = 8'h00;
      rsp_ch.ready = 1'b0;

      // Directed: field extremes, every operation and class, and the corner cases.
      add_item(OP_TRACK_BYTE, DT_RAW, 8'h00);
      add_item(OP_TRACK_BYTE, DT_RAW, 8'hFF);
      add_item(OP_TRACK_BYTE, DT_FULL, 8'h5A);
      add_item(OP_TRACK_BYTE, DT_EVEN, 8'hFF);
      add_item(OP_TRACK_BYTE, DT_ODD, 8'h00);
      // A half left alone when a sync byte arrives is dropped.
      add_item(OP_TRACK_BYTE, DT_EVEN, 8'hAA);
      add_item(OP_TRACK_BYTE, DT_RAW, 8'h55);
      add_item(OP_START_TRACK, DT_ODD, 8'hFF);
      add_item(OP_TRACK_BYTE, DT_FULL, 8'h81);
      add_item(OP_TRACK_BYTE, DT_ODD, 8'h55);
      add_item(OP_END_TRACK, DT_EVEN, 8'hAA);
      // Track bytes after the end of a track close a chunk with no code.
      add_item(OP_TRACK_BYTE, DT_RAW, 8'h12);
      add_item(2'd3, DT_ODD, 8'hFF);
      add_item(OP_END_TRACK, DT_RAW, 8'h00);
      add_item(OP_END_TRACK, DT_FULL, 8'hFF);
      add_item(OP_TRACK_BYTE, DT_FULL, 8'hFF);
      add_item(OP_TRACK_BYTE, DT_EVEN, 8'h00);
      add_item(OP_TRACK_BYTE, DT_ODD, 8'hFF);
      add_item(OP_TRACK_BYTE, DT_ODD, 8'h55);
      add_item(OP_TRACK_BYTE, DT_EVEN, 8'hAA);
      add_item(OP_START_TRACK, DT_RAW, 8'h00);
      add_item(OP_TRACK_BYTE, DT_EVEN, 8'h0F);
      add_item(OP_TRACK_BYTE, DT_FULL, 8'h00);
      add_item(OP_END_TRACK, DT_ODD, 8'h55);

      // Random tracks: sync runs and data runs, with some noise mixed in.
      target = track_items.size() + 40;
      while (track_items.size() < target) begin
         if ($urandom_range(0, 9) != 0) add_item(OP_START_TRACK, 2'($urandom), 8'($urandom));
         n_runs = $urandom_range(1, 5);
         repeat (n_runs) begin
            n = $urandom_range(1, 4);
            repeat (n) add_item(OP_TRACK_BYTE, DT_RAW, 8'($urandom));
            mode = $urandom_range(0, 3);
            n = $urandom_range(1, 10);
            if (mode == 1) n = 2 * n;
            for (int k = 0; k < n; k++) begin
               case (mode)
                  0: dc = DT_FULL;
                  1: dc = k[0] ? DT_ODD : DT_EVEN;
                  2: dc = 2'($urandom_range(1, 3));
                  default: dc = k[0] ? DT_EVEN : DT_ODD;
               endcase
               add_item(OP_TRACK_BYTE, dc, 8'($urandom));
               if ($urandom_range(0, 19) == 0) begin
                  add_item(2'($urandom_range(0, 3)), 2'($urandom), 8'($urandom));
               end
            end
         end
         if ($urandom_range(0, 7) != 0) add_item(OP_END_TRACK, 2'($urandom), 8'($urandom));
      end

      // One data chunk longer than 255 bytes so its count needs two bytes.
      add_item(OP_START_TRACK, DT_RAW, 8'h00);
      add_item(OP_TRACK_BYTE, DT_RAW, 8'($urandom));
      repeat (256) add_item(OP_TRACK_BYTE, DT_FULL, 8'($urandom));
      add_item(OP_TRACK_BYTE, DT_EVEN, 8'($urandom));
      add_item(OP_TRACK_BYTE, DT_ODD, 8'($urandom));
      add_item(OP_END_TRACK, DT_RAW, 8'h00);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Drain: all items accepted, all results returned, then a quiet tail.
      while (track_items.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d track items and %0d results: %0d payload bytes,",
               accepted_items, results_seen, payload_seen);
      $display("%0d chunk records (%0d with two-byte counts) and %0d block records.",
               chunks_seen, wide_chunks, blocks_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
